/* design/tcsc_pkg.sv */
package tcsc_pkg;

  localparam int COL_W       = 10;
  localparam int DIM_W       = 11;
  localparam int PTR_W       = 13;
  localparam int THR_W       = 47;
  localparam int CFG_DATA_W  = 47;
  localparam int MAX_DIM     = 1024;
  localparam int MAX_NONZERO = 4096;
  localparam int VALUE_WIDTH = 48;
  localparam int RES_LANES   = 4;
  localparam int QUEUE_DEPTH = 8;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(16);

  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_RANGE = 1'b1;

  typedef enum logic [0:0] {
    CFG_DIMENSION      = 1'b0,
    CFG_DROP_THRESHOLD = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] dim;
    logic [THR_W-1:0] thr;
  } cfg_t;

  typedef struct packed {
    logic             kind;
    logic [COL_W-1:0] row;
    logic [DIM_W-1:0] first;
    logic [DIM_W-1:0] last;
    logic [PTR_W-1:0] ptr;
    logic             eor;
  } res_hdr_t;

endpackage

/* design/tcsc_step.sv */
module tcsc_step #(
  parameter int VALUE_WIDTH = tcsc_pkg::VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcsc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcsc_pkg::COL_W-1:0]    in_col,
  input  logic [tcsc_pkg::COL_W-1:0]    in_row,
  input  logic signed [VALUE_WIDTH-1:0] in_val,
  input  logic                          in_fin,
  input  logic                          room,
  output logic [tcsc_pkg::RES_LANES-1:0] push_vld,
  output tcsc_pkg::res_hdr_t            push_hdr [tcsc_pkg::RES_LANES],
  output logic signed [VALUE_WIDTH-1:0] push_val [tcsc_pkg::RES_LANES]
);

  localparam int MAX_NONZERO = tcsc_pkg::MAX_NONZERO;
  localparam int CNT_W = $clog2(MAX_NONZERO + 1);
  localparam int COL_W = tcsc_pkg::COL_W;
  localparam int DIM_W = tcsc_pkg::DIM_W;
  localparam int PTR_W = tcsc_pkg::PTR_W;
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  function automatic logic [VALUE_WIDTH-1:0] mag(input logic signed [VALUE_WIDTH-1:0] s);
    mag = s[VALUE_WIDTH-1] ? (~s + VALUE_WIDTH'(1)) : s;
  endfunction

  logic                          vld_r;
  logic [COL_W-1:0]              col_r;
  logic [COL_W-1:0]              row_r;
  logic signed [VALUE_WIDTH-1:0] val_r;
  logic                          fin_r;

  logic [COL_W-1:0]              ocol_r, ocol_nxt;
  logic [COL_W-1:0]              orow_r, orow_nxt;
  logic signed [VALUE_WIDTH-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  logic                          fire;
  logic                          same;
  logic signed [VALUE_WIDTH:0]   wide;
  logic signed [VALUE_WIDTH-1:0] sum_add;
  logic signed [VALUE_WIDTH-1:0] sum_mid;
  logic [VALUE_WIDTH-1:0]        thr_cmp;
  logic [DIM_W-1:0]              dim_cl;
  logic                          e1, r1, e2, r2;
  logic [CNT_W-1:0]              cnt1, cnt2;
  logic [tcsc_pkg::RES_LANES-1:0] v;

  assign fire     = vld_r && room;
  assign in_stall = vld_r && !room;

  always_comb begin
    same    = (col_r == ocol_r) && (row_r == orow_r);
    wide    = {sum_r[VALUE_WIDTH-1], sum_r} + {val_r[VALUE_WIDTH-1], val_r};
    if (wide[VALUE_WIDTH] != wide[VALUE_WIDTH-1]) begin
      sum_add = wide[VALUE_WIDTH] ? VMIN : VMAX;
    end else begin
      sum_add = wide[VALUE_WIDTH-1:0];
    end
    sum_mid = same ? sum_add : val_r;
    thr_cmp = VALUE_WIDTH'((VALUE_WIDTH-1)'(cfg.thr));
    dim_cl  = (cfg.dim > DIM_W'(tcsc_pkg::MAX_DIM)) ? DIM_W'(tcsc_pkg::MAX_DIM) : cfg.dim;

    e1   = !same && (mag(sum_r) > thr_cmp) && (cnt_r < CNT_W'(MAX_NONZERO));
    cnt1 = cnt_r + CNT_W'(e1);
    r1   = !same && (col_r > ocol_r);
    e2   = fin_r && (mag(sum_mid) > thr_cmp) && (cnt1 < CNT_W'(MAX_NONZERO));
    cnt2 = cnt1 + CNT_W'(e2);
    r2   = fin_r && ({1'b0, col_r} < dim_cl);
    v    = {r2, e2, r1, e1};

    push_vld = fire ? v : '0;

    push_hdr[0] = '{kind: tcsc_pkg::KIND_ENTRY, row: orow_r, first: '0, last: '0,
                    ptr: '0, eor: v[0] && !(|v[3:1])};
    push_val[0] = sum_r;
    push_hdr[1] = '{kind: tcsc_pkg::KIND_RANGE, row: '0,
                    first: {1'b0, ocol_r} + DIM_W'(1), last: {1'b0, col_r},
                    ptr: PTR_W'(cnt1), eor: v[1] && !(|v[3:2])};
    push_val[1] = '0;
    push_hdr[2] = '{kind: tcsc_pkg::KIND_ENTRY, row: row_r, first: '0, last: '0,
                    ptr: '0, eor: v[2] && !v[3]};
    push_val[2] = sum_mid;
    push_hdr[3] = '{kind: tcsc_pkg::KIND_RANGE, row: '0,
                    first: {1'b0, col_r} + DIM_W'(1), last: dim_cl,
                    ptr: PTR_W'(cnt2), eor: v[3]};
    push_val[3] = '0;

    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    if (fire) begin
      if (fin_r) begin
        ocol_nxt = '0;
        orow_nxt = '0;
        sum_nxt  = '0;
        cnt_nxt  = '0;
      end else begin
        ocol_nxt = col_r;
        orow_nxt = row_r;
        sum_nxt  = sum_mid;
        cnt_nxt  = cnt1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      ocol_r <= '0;
      orow_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        vld_r <= 1'b1;
      end else if (fire) begin
        vld_r <= 1'b0;
      end
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      col_r <= in_col;
      row_r <= in_row;
      val_r <= in_val;
      fin_r <= in_fin;
    end
  end

endmodule

/* design/tcsc_queue.sv */
module tcsc_queue #(
  parameter int VALUE_WIDTH = tcsc_pkg::VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [tcsc_pkg::RES_LANES-1:0] push_vld,
  input  tcsc_pkg::res_hdr_t             push_hdr [tcsc_pkg::RES_LANES],
  input  logic signed [VALUE_WIDTH-1:0]  push_val [tcsc_pkg::RES_LANES],
  output logic                           room,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tcsc_pkg::res_hdr_t             out_hdr,
  output logic signed [VALUE_WIDTH-1:0]  out_val
);

  localparam int DEPTH = tcsc_pkg::QUEUE_DEPTH;
  localparam int LANES = tcsc_pkg::RES_LANES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  tcsc_pkg::res_hdr_t            hdr_r [DEPTH];
  logic signed [VALUE_WIDTH-1:0] val_r [DEPTH];
  logic [AW-1:0]                 wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [AW-1:0]                 wr_idx [LANES];
  logic [CW-1:0]                 push_n;
  logic                          pop;

  assign out_valid = (cnt_r != '0);
  assign room      = (cnt_r <= CW'(DEPTH - LANES));
  assign pop       = out_valid && !out_stall;
  assign out_hdr   = hdr_r[rd_ptr_r];
  assign out_val   = val_r[rd_ptr_r];

  always_comb begin
    logic [AW-1:0] offs;
    offs   = '0;
    push_n = '0;
    for (int j = 0; j < LANES; j++) begin
      wr_idx[j] = wr_ptr_r + offs;
      offs      = offs + AW'(push_vld[j]);
      push_n    = push_n + CW'(push_vld[j]);
    end
    wr_ptr_nxt = wr_ptr_r + AW'(push_n);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    cnt_nxt    = cnt_r + push_n - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < LANES; j++) begin
      if (push_vld[j]) begin
        hdr_r[wr_idx[j]] <= push_hdr[j];
        val_r[wr_idx[j]] <= push_val[j];
      end
    end
  end

endmodule

/* design/triplet_to_csc_assembler_core.sv */
// Triplet to CSC assembler.
// Input channel (in_*): one triplet per word, ordered by column then row; the
// word flagged in_final_triplet closes the matrix. Output channel (out_*): a
// stream of nonzero entry words (out_kind 0) and column pointer range words
// (out_kind 1); out_end_of_run marks the last word caused by one triplet.
// Configuration (cfg_*): index 0 dimension, index 1 drop threshold; cfg_ready
// is always high. Write only while the block is idle.
// A triplet's words are formed from the input register and written into the
// queue, from which the output port offers them.
// Throughput: one triplet per cycle while each gives at most one word and the
// receiver does not stall; a triplet giving k words offers them one by one on the
// single output port, and up to four words come from one triplet. An input
// register feeds the accumulate and flush logic, whose words go into an eight
// word queue; a triplet is processed once the queue has room for four words.
// When the receiver stalls, the queue fills and in_stall rises; nothing is lost.
// Reset clears the queue and the running state and loads dimension 1024 and
// threshold 16.
module triplet_to_csc_assembler_core #(
  parameter int VALUE_WIDTH = tcsc_pkg::VALUE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [0:0]                        cfg_index,
  input  logic [tcsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tcsc_pkg::COL_W-1:0]        in_col_index,
  input  logic [tcsc_pkg::COL_W-1:0]        in_row_index,
  input  logic signed [VALUE_WIDTH-1:0]     in_entry_in,
  input  logic                              in_final_triplet,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_kind,
  output logic [tcsc_pkg::COL_W-1:0]        out_entry_row,
  output logic signed [VALUE_WIDTH-1:0]     out_entry_out,
  output logic [tcsc_pkg::DIM_W-1:0]        out_range_first,
  output logic [tcsc_pkg::DIM_W-1:0]        out_range_last,
  output logic [tcsc_pkg::PTR_W-1:0]        out_pointer_value,
  output logic                              out_end_of_run
);

  tcsc_pkg::cfg_t                 cfg_r;
  logic                           room;
  logic [tcsc_pkg::RES_LANES-1:0] push_vld;
  logic [tcsc_pkg::RES_LANES-1:0] push_eor;
  tcsc_pkg::res_hdr_t             push_hdr [tcsc_pkg::RES_LANES];
  logic signed [VALUE_WIDTH-1:0]  push_val [tcsc_pkg::RES_LANES];
  tcsc_pkg::res_hdr_t             head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim <= tcsc_pkg::DIM_RESET;
      cfg_r.thr <= tcsc_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (tcsc_pkg::cfg_idx_t'(cfg_index))
        tcsc_pkg::CFG_DIMENSION:      cfg_r.dim <= cfg_data[tcsc_pkg::DIM_W-1:0];
        tcsc_pkg::CFG_DROP_THRESHOLD: cfg_r.thr <= cfg_data[tcsc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  tcsc_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_col   (in_col_index),
    .in_row   (in_row_index),
    .in_val   (in_entry_in),
    .in_fin   (in_final_triplet),
    .room     (room),
    .push_vld (push_vld),
    .push_hdr (push_hdr),
    .push_val (push_val)
  );

  tcsc_queue #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (push_vld),
    .push_hdr  (push_hdr),
    .push_val  (push_val),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_hdr   (head),
    .out_val   (out_entry_out)
  );

  assign out_kind          = head.kind;
  assign out_entry_row     = head.row;
  assign out_range_first   = head.first;
  assign out_range_last    = head.last;
  assign out_pointer_value = head.ptr;
  assign out_end_of_run    = head.eor;

  always_comb begin
    for (int j = 0; j < tcsc_pkg::RES_LANES; j++) begin
      push_eor[j] = push_vld[j] && push_hdr[j].eor;
    end
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (|push_vld) |-> room)
    else $error("words pushed without queue room");

  a_one_eor: assert property (@(posedge clk) disable iff (!rst_n)
    (|push_vld) |-> $onehot(push_eor))
    else $error("pushed group lacks a single end of run");

  a_stall_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (push_vld == '0))
    else $error("push while input stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

/* dv/triplet_to_csc_assembler_core_test.sv */
`timescale 1ns / 100ps

module triplet_to_csc_assembler_core_test;

  localparam logic [47:0] VMAX_W = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] VMIN_W = 48'h8000_0000_0000;
  localparam logic [47:0] NEG_17 = 48'hFFFF_FFFF_FFEF;

  typedef struct packed {
    logic        kind;
    logic [9:0]  row;
    logic [47:0] val;
    logic [10:0] first;
    logic [10:0] last;
    logic [12:0] ptr;
    logic        eor;
  } csc_word_t;

  localparam csc_word_t NO_WORD = '0;

  typedef struct {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [47:0] val;
    logic        fin;
    bit          typed;
    int          n_due;
    csc_word_t   want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [0:0]        cfg_index;
  logic [46:0]       cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [9:0]        in_col_index;
  logic [9:0]        in_row_index;
  logic signed [47:0] in_entry_in;
  logic              in_final_triplet;
  logic              out_valid;
  logic              out_stall;
  logic              out_kind;
  logic [9:0]        out_entry_row;
  logic signed [47:0] out_entry_out;
  logic [10:0]       out_range_first;
  logic [10:0]       out_range_last;
  logic [12:0]       out_pointer_value;
  logic              out_end_of_run;

  triplet_to_csc_assembler_core i_dut (.*);

  // predictor state and register copies
  logic [9:0]  acc_col;
  logic [9:0]  acc_row;
  logic [47:0] acc_sum;
  logic [12:0] nnz_count;
  logic [10:0] dim_reg;
  logic [46:0] thr_reg;

  csc_word_t step_words[$];
  csc_word_t csc_words_due[$];
  int        fail_cnt = 0;
  int        items_sent = 0;
  bit        calm = 1'b0;
  bit        squeeze_req = 1'b0;

  dir_row_t opening_rows [14] = '{
    '{10'd0, 10'd0, 48'd100, 1'b0, 1'b1, 0, NO_WORD},
    '{10'd0, 10'd0, 48'd5, 1'b0, 1'b1, 0, NO_WORD},
    '{10'd0, 10'd3, VMAX_W, 1'b0, 1'b1, 1,
      csc_word_t'{tcsc_pkg::KIND_ENTRY, 10'd0, 48'd105, 11'd0, 11'd0, 13'd0, 1'b1}},
    '{10'd0, 10'd3, VMAX_W, 1'b0, 1'b1, 0, NO_WORD},
    '{10'd0, 10'd4, VMIN_W, 1'b0, 1'b1, 1,
      csc_word_t'{tcsc_pkg::KIND_ENTRY, 10'd3, VMAX_W, 11'd0, 11'd0, 13'd0, 1'b1}},
    '{10'd0, 10'd4, VMIN_W, 1'b0, 1'b1, 0, NO_WORD},
    '{10'd2, 10'd1, 48'd16, 1'b0, 1'b0, 0, NO_WORD},
    '{10'd2, 10'd5, NEG_17, 1'b0, 1'b1, 0, NO_WORD},
    '{10'd2, 10'd2, 48'd40, 1'b0, 1'b1, 1,
      csc_word_t'{tcsc_pkg::KIND_ENTRY, 10'd5, NEG_17, 11'd0, 11'd0, 13'd0, 1'b1}},
    '{10'd1, 10'd0, 48'd7, 1'b0, 1'b1, 1,
      csc_word_t'{tcsc_pkg::KIND_ENTRY, 10'd2, 48'd40, 11'd0, 11'd0, 13'd0, 1'b1}},
    '{10'd1023, 10'd1023, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 0, NO_WORD},
    '{10'd0, 10'd0, 48'd0, 1'b1, 1'b1, 1,
      csc_word_t'{tcsc_pkg::KIND_RANGE, 10'd0, 48'd0, 11'd1, 11'd1024, 13'd0, 1'b1}},
    '{10'd5, 10'd1023, 48'd1, 1'b0, 1'b0, 0, NO_WORD},
    '{10'd5, 10'd1023, 48'd16, 1'b1, 1'b0, 0, NO_WORD}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void close_sum();
    logic [47:0] mag;
    mag = acc_sum[47] ? (~acc_sum + 48'd1) : acc_sum;
    if (mag > {1'b0, thr_reg} && nnz_count < tcsc_pkg::MAX_NONZERO) begin
      step_words.push_back(csc_word_t'{tcsc_pkg::KIND_ENTRY, acc_row, acc_sum, 11'd0, 11'd0,
                                       13'd0, 1'b0});
      nnz_count++;
    end
  endfunction

  function automatic void assemble_triplet(input logic [9:0] col, input logic [9:0] row,
                                           input logic [47:0] val, input logic fin);
    logic [48:0] wide;
    logic [10:0] n;
    step_words.delete();
    if (col == acc_col && row == acc_row) begin
      wide = {acc_sum[47], acc_sum} + {val[47], val};
      if (wide[48] != wide[47]) acc_sum = wide[48] ? VMIN_W : VMAX_W;
      else acc_sum = wide[47:0];
    end else begin
      close_sum();
      if (col > acc_col)
        step_words.push_back(csc_word_t'{tcsc_pkg::KIND_RANGE, 10'd0, 48'd0,
                                         {1'b0, acc_col} + 11'd1, {1'b0, col}, nnz_count,
                                         1'b0});
      acc_col = col;
      acc_row = row;
      acc_sum = val;
    end
    if (fin) begin
      n = (dim_reg > tcsc_pkg::MAX_DIM) ? 11'(tcsc_pkg::MAX_DIM) : dim_reg;
      close_sum();
      if ({1'b0, acc_col} < n)
        step_words.push_back(csc_word_t'{tcsc_pkg::KIND_RANGE, 10'd0, 48'd0,
                                         {1'b0, acc_col} + 11'd1, n, nnz_count, 1'b0});
      acc_col = '0;
      acc_row = '0;
      acc_sum = '0;
      nnz_count = '0;
    end
    if (step_words.size() != 0) step_words[step_words.size() - 1].eor = 1'b1;
  endfunction

  function automatic void match(input string what, input logic [47:0] want,
                                input logic [47:0] got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  function automatic void take_word();
    csc_word_t due;
    if (csc_words_due.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 40)
        $display("%0t: unexpected word, expected none, actual kind %0d row %0d val %0h",
                 $time, out_kind, out_entry_row, out_entry_out);
    end else begin
      due = csc_words_due.pop_front();
      match("kind", 48'(due.kind), 48'(out_kind));
      match("entry_row", 48'(due.row), 48'(out_entry_row));
      match("entry_out", due.val, out_entry_out);
      match("range_first", 48'(due.first), 48'(out_range_first));
      match("range_last", 48'(due.last), 48'(out_range_last));
      match("pointer_value", 48'(due.ptr), 48'(out_pointer_value));
      match("end_of_run", 48'(due.eor), 48'(out_end_of_run));
    end
  endfunction

  // receiver: random stall, plus one long hold on request
  initial begin
    int hold_left;
    bit squeezed;
    hold_left = 0;
    squeezed = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) take_word();
      if (squeeze_req && !squeezed) begin
        hold_left = 80;
        squeezed = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 38);
      end
    end
  end

  task automatic offer(input logic [9:0] col, input logic [9:0] row, input logic [47:0] val,
                       input logic fin);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_col_index <= col;
    in_row_index <= row;
    in_entry_in <= val;
    in_final_triplet <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send(input logic [9:0] col, input logic [9:0] row, input logic [47:0] val,
                      input logic fin);
    offer(col, row, val, fin);
    assemble_triplet(col, row, val, fin);
    foreach (step_words[j]) csc_words_due.push_back(step_words[j]);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (csc_words_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [10:0] dim, input logic [46:0] thr);
    logic [46:0] dim_word;
    drain();
    dim_word = 47'({$urandom, $urandom});
    dim_word[10:0] = dim;
    cfg_valid <= 1'b1;
    cfg_index <= tcsc_pkg::CFG_DIMENSION;
    cfg_data <= dim_word;
    do @(posedge clk); while (!cfg_ready);
    dim_reg = dim;
    cfg_index <= tcsc_pkg::CFG_DROP_THRESHOLD;
    cfg_data <= thr;
    do @(posedge clk); while (!cfg_ready);
    thr_reg = thr;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] pick_entry();
    logic [47:0] mag;
    case ($urandom_range(7))
      0: return VMAX_W;
      1: return VMIN_W;
      2: begin
        mag = {1'b0, thr_reg} + 48'($urandom_range(1));
        return $urandom_range(1) ? -mag : mag;
      end
      3: begin
        mag = 48'($urandom_range(64));
        return $urandom_range(1) ? -mag : mag;
      end
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  // mostly ordered triplets; a few go backwards or drop the closing flag
  task automatic send_matrix(input int len);
    logic [9:0]  col;
    logic [9:0]  row;
    logic [10:0] nxt;
    int          pick;
    logic        fin;
    col = 10'($urandom_range(3));
    row = 10'($urandom_range(15));
    for (int i = 0; i < len; i++) begin
      if (i != 0) begin
        pick = $urandom_range(99);
        if (pick >= 25 && pick < 55) begin
          nxt = {1'b0, row} + 11'($urandom_range(1, 40));
          row = (nxt > 11'd1023) ? 10'd1023 : nxt[9:0];
        end else if (pick >= 55 && pick < 90) begin
          nxt = {1'b0, col} + 11'($urandom_range(3) == 0 ? $urandom_range(1, 400)
                                                          : $urandom_range(1, 3));
          col = (nxt > 11'd1023) ? 10'd1023 : nxt[9:0];
          row = 10'($urandom_range(1) ? $urandom_range(15) : $urandom_range(1023));
        end else if (pick >= 90) begin
          col = 10'($urandom_range(1023));
          row = 10'($urandom_range(1023));
        end
      end
      fin = (i == len - 1) && ($urandom_range(19) != 0);
      send(col, row, pick_entry(), fin);
    end
  endtask

  task automatic send_random(input int n);
    int goal;
    goal = items_sent + n;
    while (items_sent < goal)
      send_matrix($urandom_range(9) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12));
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tcsc_pkg::CFG_DIMENSION;
    cfg_data = '0;
    in_valid = 1'b0;
    in_col_index = '0;
    in_row_index = '0;
    in_entry_in = '0;
    in_final_triplet = 1'b0;
    dim_reg = tcsc_pkg::DIM_RESET;
    thr_reg = tcsc_pkg::THR_RESET;
    acc_col = '0;
    acc_row = '0;
    acc_sum = '0;
    nnz_count = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i]) begin
      offer(opening_rows[i].col, opening_rows[i].row, opening_rows[i].val,
            opening_rows[i].fin);
      assemble_triplet(opening_rows[i].col, opening_rows[i].row, opening_rows[i].val,
                       opening_rows[i].fin);
      if (opening_rows[i].typed) begin
        if (opening_rows[i].n_due != 0) csc_words_due.push_back(opening_rows[i].want);
      end else begin
        foreach (step_words[j]) csc_words_due.push_back(step_words[j]);
      end
    end

    reconfigure(11'd1024, 47'd0);
    calm = 1'b1;
    squeeze_req = 1'b1;
    send_random(27);
    calm = 1'b0;
    reconfigure(11'd1, {47{1'b1}});
    send_random(27);
    reconfigure(11'd0, 47'({$urandom, $urandom}));
    send_random(27);
    reconfigure(11'd2047, 47'($urandom_range(4096)));
    send_random(27);
    reconfigure(11'($urandom_range(1, 1024)),
                47'({$urandom, $urandom}) >> $urandom_range(20, 46));
    send_random(27);

    drain();
    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
